@@ hdl/eit_event_header_encoder_top_defines.svh @@
// Assertion macros used by the event header encoder RTL.
`ifndef EIT_EVENT_HEADER_ENCODER_TOP_DEFINES_SVH
`define EIT_EVENT_HEADER_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define EIT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define EIT_ASSERT_IN_RESET(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) !rst_n |-> (prop)) else $error(msg);

`else

`define EIT_ASSERT(lbl, clk, rst_n, prop, msg)

`define EIT_ASSERT_IN_RESET(lbl, clk, rst_n, prop, msg)

`endif

`endif

@@ hdl/eit_pkg.sv @@
// Types, constants and helper functions of the EIT event header encoder.
package eit_pkg;

    localparam int STAGES = 5;

    localparam logic [18:0] DUR_MAX       = 19'd359999;
    localparam logic [23:0] DUR_CLIP_BCD  = 24'h995959;
    localparam logic [20:0] HOUR_RECIP    = 21'd1193047;
    localparam int          HOUR_SHIFT    = 32;
    localparam logic [18:0] SEC_PER_HOUR  = 19'd3600;
    localparam logic [12:0] MIN_RECIP     = 13'd4370;
    localparam int          MIN_SHIFT     = 18;
    localparam logic [11:0] SEC_PER_MIN   = 12'd60;
    localparam logic [15:0] MJD_BASE      = 16'd14956;
    localparam logic [18:0] DAYS_PER_4Y   = 19'd1461;
    localparam logic [15:0] YTERM_NEG     = 16'hFE93;

    typedef struct packed {
        logic [15:0] event_id;
        logic [7:0]  year_since_1900;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [19:0] duration_seconds;
        logic [2:0]  running_status;
        logic        free_ca_mode;
        logic [11:0] descriptors_length;
    } evt_t;

    typedef struct packed {
        logic [15:0] event_id_out;
        logic [15:0] start_mjd;
        logic [23:0] start_time_bcd;
        logic [23:0] duration_bcd;
        logic [15:0] status_length_word;
        logic        duration_clipped;
    } hdr_t;

    typedef struct packed {
        logic [STAGES-1:0] load;
    } pipe_ctl_t;

    function automatic logic [7:0] bcd2(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  tens;
        logic [3:0]  units;
        p     = 15'(v) * 15'd205;
        tens  = 4'(p >> 11);
        units = 4'(v - 7'(tens) * 7'd10);
        return {tens, units};
    endfunction

    function automatic logic [8:0] month_term(input logic [3:0] m);
        logic [8:0] t;
        unique case (m)
            4'd0:    t = 9'd30;
            4'd1:    t = 9'd428;
            4'd2:    t = 9'd459;
            4'd3:    t = 9'd122;
            4'd4:    t = 9'd153;
            4'd5:    t = 9'd183;
            4'd6:    t = 9'd214;
            4'd7:    t = 9'd244;
            4'd8:    t = 9'd275;
            4'd9:    t = 9'd306;
            4'd10:   t = 9'd336;
            4'd11:   t = 9'd367;
            4'd12:   t = 9'd397;
            4'd13:   t = 9'd428;
            4'd14:   t = 9'd459;
            default: t = 9'd489;
        endcase
        return t;
    endfunction

endpackage

@@ hdl/eit_pipe_ctl.sv @@
// Valid bits and per-stage load enables of the encoder pipeline.
`include "eit_event_header_encoder_top_defines.svh"

module eit_pipe_ctl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output eit_pkg::pipe_ctl_t ctl
);

    logic [eit_pkg::STAGES-1:0] valid_reg;
    logic [eit_pkg::STAGES-1:0] valid_next;
    logic [eit_pkg::STAGES-1:0] load;

    always_comb
    begin
        load[eit_pkg::STAGES-1] = !valid_reg[eit_pkg::STAGES-1] || !out_stall;
        for (int i = eit_pkg::STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < eit_pkg::STAGES; i++)
        begin
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.load  = load;
    assign in_stall  = !load[0];
    assign out_valid = valid_reg[eit_pkg::STAGES-1];

    `EIT_ASSERT(a_stall_only_when_full, clk, rst_n, in_stall |-> ((&valid_reg) && out_stall), "input stalled with a free stage")
    `EIT_ASSERT(a_accept_enters, clk, rst_n, (in_valid && !in_stall) |=> valid_reg[0], "accepted beat missing from first stage")
    `EIT_ASSERT(a_no_loss_mid, clk, rst_n, (valid_reg[3] && !load[4]) |=> valid_reg[3], "held beat dropped in stage 3")
    `EIT_ASSERT_IN_RESET(a_reset_empty, clk, rst_n, valid_reg == '0, "pipeline not empty in reset")

endmodule

@@ hdl/eit_dur_pipe.sv @@
// Duration saturation, split into hours, minutes and seconds, and BCD coding.
module eit_dur_pipe
(
    input  logic               clk,
    input  eit_pkg::pipe_ctl_t ctl,
    input  logic [19:0]        duration_seconds,
    output logic [23:0]        duration_bcd,
    output logic               duration_clipped
);

    logic [18:0] dur0_reg;
    logic [18:0] dur1_reg;
    logic [11:0] rem2_reg;
    logic [11:0] rem3_reg;
    logic [6:0]  hours1_reg;
    logic [6:0]  hours2_reg;
    logic [6:0]  hours3_reg;
    logic [5:0]  min3_reg;
    logic [23:0] bcd4_reg;
    logic [eit_pkg::STAGES-1:0] clip_reg;

    logic        clip_next;
    logic [18:0] dur_next;
    logic [39:0] hour_prod;
    logic [6:0]  hours_next;
    logic [18:0] rem_full;
    logic [24:0] min_prod;
    logic [5:0]  min_next;
    logic [11:0] sec_full;
    logic [23:0] bcd_next;

    always_comb
    begin
        clip_next  = duration_seconds > 20'(eit_pkg::DUR_MAX);
        dur_next   = clip_next ? eit_pkg::DUR_MAX : 19'(duration_seconds);
        hour_prod  = 40'(dur0_reg) * 40'(eit_pkg::HOUR_RECIP);
        hours_next = 7'(hour_prod >> eit_pkg::HOUR_SHIFT);
        rem_full   = dur1_reg - 19'(hours1_reg) * eit_pkg::SEC_PER_HOUR;
        min_prod   = 25'(rem2_reg) * 25'(eit_pkg::MIN_RECIP);
        min_next   = 6'(min_prod >> eit_pkg::MIN_SHIFT);
        sec_full   = rem3_reg - 12'(min3_reg) * eit_pkg::SEC_PER_MIN;
        bcd_next   = {eit_pkg::bcd2(hours3_reg), eit_pkg::bcd2(7'(min3_reg)),
                      eit_pkg::bcd2(7'(sec_full))};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            dur0_reg    <= dur_next;
            clip_reg[0] <= clip_next;
        end
        if (ctl.load[1])
        begin
            dur1_reg    <= dur0_reg;
            hours1_reg  <= hours_next;
            clip_reg[1] <= clip_reg[0];
        end
        if (ctl.load[2])
        begin
            rem2_reg    <= 12'(rem_full);
            hours2_reg  <= hours1_reg;
            clip_reg[2] <= clip_reg[1];
        end
        if (ctl.load[3])
        begin
            rem3_reg    <= rem2_reg;
            min3_reg    <= min_next;
            hours3_reg  <= hours2_reg;
            clip_reg[3] <= clip_reg[2];
        end
        if (ctl.load[4])
        begin
            bcd4_reg    <= bcd_next;
            clip_reg[4] <= clip_reg[3];
        end
    end

    assign duration_bcd     = bcd4_reg;
    assign duration_clipped = clip_reg[eit_pkg::STAGES-1];

endmodule

@@ hdl/eit_hdr_pipe.sv @@
// MJD computation, start time BCD and header pass-through fields.
module eit_hdr_pipe
(
    input  logic               clk,
    input  eit_pkg::pipe_ctl_t ctl,
    input  eit_pkg::evt_t      evt,
    output logic [15:0]        event_id_out,
    output logic [15:0]        start_mjd,
    output logic [23:0]        start_time_bcd,
    output logic [15:0]        status_length_word
);

    logic [15:0] eid_reg  [eit_pkg::STAGES];
    logic [23:0] time_reg [eit_pkg::STAGES];
    logic [15:0] stat_reg [eit_pkg::STAGES];

    logic        yneg0_reg;
    logic [7:0]  ymag0_reg;
    logic [8:0]  mterm0_reg;
    logic [8:0]  mterm1_reg;
    logic [4:0]  day0_reg;
    logic [4:0]  day1_reg;
    logic [15:0] yterm1_reg;
    logic [15:0] mjd2_reg;
    logic [15:0] mjd3_reg;
    logic [15:0] mjd4_reg;

    logic        leap_next;
    logic [8:0]  yl_next;
    logic [18:0] yprod;
    logic [15:0] yterm_next;
    logic [15:0] mjd_next;

    always_comb
    begin
        leap_next  = (evt.month == 4'd1) || (evt.month == 4'd2);
        yl_next    = {1'b0, evt.year_since_1900} - 9'(leap_next);
        yprod      = 19'(ymag0_reg) * eit_pkg::DAYS_PER_4Y;
        yterm_next = yneg0_reg ? eit_pkg::YTERM_NEG : 16'(yprod >> 2);
        mjd_next   = eit_pkg::MJD_BASE + 16'(day1_reg) + yterm1_reg + 16'(mterm1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            yneg0_reg   <= yl_next[8];
            ymag0_reg   <= yl_next[7:0];
            mterm0_reg  <= eit_pkg::month_term(evt.month);
            day0_reg    <= evt.day;
            eid_reg[0]  <= evt.event_id;
            time_reg[0] <= {eit_pkg::bcd2(7'(evt.hour)), eit_pkg::bcd2(7'(evt.minute)),
                            eit_pkg::bcd2(7'(evt.second))};
            stat_reg[0] <= {evt.running_status, evt.free_ca_mode, evt.descriptors_length};
        end
        if (ctl.load[1])
        begin
            yterm1_reg <= yterm_next;
            mterm1_reg <= mterm0_reg;
            day1_reg   <= day0_reg;
        end
        if (ctl.load[2])
        begin
            mjd2_reg <= mjd_next;
        end
        if (ctl.load[3])
        begin
            mjd3_reg <= mjd2_reg;
        end
        if (ctl.load[4])
        begin
            mjd4_reg <= mjd3_reg;
        end
        for (int i = 1; i < eit_pkg::STAGES; i++)
        begin
            if (ctl.load[i])
            begin
                eid_reg[i]  <= eid_reg[i-1];
                time_reg[i] <= time_reg[i-1];
                stat_reg[i] <= stat_reg[i-1];
            end
        end
    end

    assign event_id_out       = eid_reg[eit_pkg::STAGES-1];
    assign start_mjd          = mjd4_reg;
    assign start_time_bcd     = time_reg[eit_pkg::STAGES-1];
    assign status_length_word = stat_reg[eit_pkg::STAGES-1];

endmodule

@@ hdl/eit_event_header_encoder_top.sv @@
// EIT event header encoder top level: five-stage pipeline.
// An event beat accepted at the input moves through the stage registers 0 to 4 in order
// and leaves as a result beat from stage 4.
// Throughput: one event beat per cycle while the result side does not stall; a stall on the result side backs up
// stage by stage, and bubbles are squeezed out before the input stalls.
// Reset clears the stage valid bits only; data registers are not reset.
module eit_event_header_encoder_top
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          evt_valid,
    output logic          evt_stall,
    input  eit_pkg::evt_t evt,
    output logic          hdr_valid,
    input  logic          hdr_stall,
    output eit_pkg::hdr_t hdr
);

    eit_pkg::pipe_ctl_t ctl;

    eit_pipe_ctl u_ctl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (evt_valid),
        .in_stall  (evt_stall),
        .out_valid (hdr_valid),
        .out_stall (hdr_stall),
        .ctl       (ctl)
    );

    eit_dur_pipe u_dur
    (
        .clk              (clk),
        .ctl              (ctl),
        .duration_seconds (evt.duration_seconds),
        .duration_bcd     (hdr.duration_bcd),
        .duration_clipped (hdr.duration_clipped)
    );

    eit_hdr_pipe u_hdr
    (
        .clk                (clk),
        .ctl                (ctl),
        .evt                (evt),
        .event_id_out       (hdr.event_id_out),
        .start_mjd          (hdr.start_mjd),
        .start_time_bcd     (hdr.start_time_bcd),
        .status_length_word (hdr.status_length_word)
    );

endmodule
